@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl of the tone burst generator
// depends on nothing; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/dtg_pkg.sv @@
// shared types, constants and lookup tables of the tone burst generator
// depends on nothing; used by every module of the block
package dtg_pkg;

   localparam int SINE_TABLE_ENTRIES_DEFAULT = 1024;
   localparam int PHASE_BITS_DEFAULT = 32;

   localparam int FREQ_W = 16;
   localparam int DUR_W = 16;
   localparam int SAMPLE_W = 16;
   localparam int VOL_W = 7;
   localparam int AMP_W = 15;
   localparam int LEFT_W = 20;
   localparam int MS_SHIFT = 4;           // 16 samples per ms

   localparam int FULL_SCALE = 32767;
   localparam int VOLUME_MAX = 100;
   localparam int VOLUME_RESET = 80;

   // 16000 = 125 * 2^7, step = freq * 2^(P-7) / 125
   localparam int RATE_SHIFT = 7;
   localparam int STEP_DIVISOR = 125;
   localparam int STEP_RECIP = 67109;     // ceil(2^23 / 125), exact for 16-bit freq
   localparam int RECIP_SHIFT = 23;
   localparam int QUOT_W = 10;
   localparam int RECIP_PROD_W = 33;
   localparam int REM_W = 7;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic active;
      logic last;
   } stage_type;

   typedef logic [AMP_W-1:0] amp_lut_type [2**VOL_W];

   function automatic amp_lut_type build_amp_lut();
      amp_lut_type lut;
      int vol;
      for (int v = 0; v < 2**VOL_W; v++) begin
         vol = (v > VOLUME_MAX) ? VOLUME_MAX : v;
         lut[v] = AMP_W'((FULL_SCALE * vol) / VOLUME_MAX);
      end
      return lut;
   endfunction

   // amplitude for each written volume code, codes above 100 saturate
   localparam amp_lut_type AMP_LUT = build_amp_lut();

endpackage

@@ rtl/core/dtg_sine_rom.sv @@
// sine rom with registered read, contents built at elaboration
// depends on dtg_pkg for the sample width and full scale
module dtg_sine_rom #(
   parameter int SINE_TABLE_ENTRIES = dtg_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   localparam int ADDR_W = $clog2(SINE_TABLE_ENTRIES)
) (
   input  logic                                 clock,
   input  logic                                 read_enable,
   input  logic [ADDR_W-1:0]                    read_address,
   output logic signed [dtg_pkg::SAMPLE_W-1:0]  read_data
);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [dtg_pkg::SAMPLE_W-1:0] rom_image_type [SINE_TABLE_ENTRIES];

   // quarter-wave folding, q30 taylor series to x^15, round to q15
   function automatic logic signed [dtg_pkg::SAMPLE_W-1:0] rom_entry(int idx);
      logic [63:0]        q4;
      logic [63:0]        quad;
      logic [63:0]        rem;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      q4 = 64'(idx) * 64'd4;
      quad = (q4 / SINE_TABLE_ENTRIES) & 64'd3;
      rem = q4 % SINE_TABLE_ENTRIES;
      if (quad[0]) begin
         rem = 64'(SINE_TABLE_ENTRIES) - rem;
      end
      x = (rem * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 110;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 156;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 210;
      sum = sum - $signed(term);
      if (sum < 64'sd0) begin
         sum = 64'sd0;
      end
      v = $signed(($unsigned(sum) * 64'(dtg_pkg::FULL_SCALE) + (64'd1 << 29)) >> 30);
      if (v > 64'(dtg_pkg::FULL_SCALE)) begin
         v = 64'(dtg_pkg::FULL_SCALE);
      end
      if (quad >= 64'd2) begin
         v = -v;
      end
      return dtg_pkg::SAMPLE_W'(v);
   endfunction

   function automatic rom_image_type build_rom();
      rom_image_type image;
      for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
         image[i] = rom_entry(i);
      end
      return image;
   endfunction

   localparam rom_image_type ROM_IMAGE = build_rom();

   logic signed [dtg_pkg::SAMPLE_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= ROM_IMAGE[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ rtl/core/dtg_sample_scale.sv @@
// volume scaling of a rom sample: product stage, then divide by full scale
// depends on dtg_pkg for stage_type, widths and the full-scale constant
module dtg_sample_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  dtg_pkg::stage_type                   stage_in,
   input  logic signed [dtg_pkg::SAMPLE_W-1:0]  rom_data,
   input  logic [dtg_pkg::AMP_W-1:0]            amp,
   output dtg_pkg::stage_type                   stage_out,
   output logic signed [dtg_pkg::SAMPLE_W-1:0]  sample_value
);

   localparam int MAG_W = 2 * dtg_pkg::AMP_W;

   logic [dtg_pkg::AMP_W-1:0]   rom_mag;
   logic [MAG_W-1:0]            mag_in;

   dtg_pkg::stage_type          s2_ff;
   dtg_pkg::stage_type          s2_in;
   logic [MAG_W-1:0]            s2_mag_ff;
   logic                        s2_neg_ff;

   logic [MAG_W:0]              est_sum;
   logic [dtg_pkg::SAMPLE_W-1:0] quot_est;
   logic [MAG_W:0]              rem_est;
   logic [dtg_pkg::SAMPLE_W-1:0] quot;
   logic signed [dtg_pkg::SAMPLE_W-1:0] sample_in;

   dtg_pkg::stage_type          out_ff;
   dtg_pkg::stage_type          out_in;
   logic signed [dtg_pkg::SAMPLE_W-1:0] sample_ff;

   // magnitude times amplitude, sign kept aside so the divide truncates to zero
   always_comb begin
      rom_mag = rom_data[dtg_pkg::SAMPLE_W-1] ?
                dtg_pkg::AMP_W'(-rom_data) : rom_data[dtg_pkg::AMP_W-1:0];
      mag_in = {{dtg_pkg::AMP_W{1'b0}}, rom_mag} * {{dtg_pkg::AMP_W{1'b0}}, amp};
      s2_in = advance ? stage_in : s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mag_ff <= mag_in;
         s2_neg_ff <= rom_data[dtg_pkg::SAMPLE_W-1];
      end
   end

   // m / (2^15 - 1): estimate by (m + m>>15) >> 15, low by at most one
   always_comb begin
      est_sum = {1'b0, s2_mag_ff} + {16'b0, s2_mag_ff[MAG_W-1:dtg_pkg::AMP_W]};
      quot_est = est_sum[MAG_W:dtg_pkg::AMP_W];
      rem_est = {1'b0, s2_mag_ff} - {quot_est, {dtg_pkg::AMP_W{1'b0}}}
                + {15'b0, quot_est};
      quot = (rem_est >= (MAG_W + 1)'(dtg_pkg::FULL_SCALE)) ? quot_est + 16'd1 : quot_est;
      if (!s2_ff.active) begin
         sample_in = '0;
      end else if (s2_neg_ff) begin
         sample_in = -$signed(quot);
      end else begin
         sample_in = $signed(quot);
      end
      out_in = advance ? s2_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_ff <= sample_in;
      end
   end

   assign stage_out = out_ff;
   assign sample_value = sample_ff;

endmodule

@@ rtl/core/dds_tone_burst_generator_unit.sv @@
// top level of the dds tone burst generator: command decode, tone state,
// phase accumulator and result pipeline; depends on dtg_pkg, dtg_sine_rom,
// dtg_sample_scale and assert_macros.svh
`include "assert_macros.svh"

// Sine tone bursts from a phase accumulator. A start transfer (command 0)
// loads a frequency in Hz and a duration in ms; the tone then lasts 16
// samples per ms. Each tick transfer (command 1) yields exactly one result:
// the sine sample at the current phase scaled by the volume register, with
// tone_active set, and tone_last set on the final sample of the tone; a tick
// with no tone playing yields an all-zero result and leaves the phase alone.
// Stop (command 2) ends the tone at once, and code 3 is ignored; neither
// gives a result, nor does start. Starts with zero frequency or zero
// duration are dropped. The phase advances by floor(freq*2^PHASE_BITS/16000)
// per sample and is kept across tones, so frequencies above 8 kHz alias.
// The block takes one transfer every cycle while no result waits unread:
// the phase accumulator and the sample counter each loop back through
// their own register. A tick's result passes the rom read register, the
// product register and, after the divide, the output register; the whole
// pipeline holds while a result waits unread, so the input stalls for
// every cycle that a result waits. The volume register takes a write on
// any cycle csr_write_enable is high; values above 100 act as 100. No
// clearing pass: the rom is constant.
module dds_tone_burst_generator_unit #(
   parameter int SINE_TABLE_ENTRIES = dtg_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   parameter int PHASE_BITS = dtg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [dtg_pkg::FREQ_W-1:0]           req_tone_freq_hz,
   input  logic [dtg_pkg::DUR_W-1:0]            req_tone_duration_ms,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dtg_pkg::SAMPLE_W-1:0]  rsp_sample_value,
   output logic                                 rsp_tone_active,
   output logic                                 rsp_tone_last,

   input  logic                                 csr_write_enable,
   input  logic [dtg_pkg::VOL_W-1:0]            csr_write_data
);

   localparam int ADDR_W = $clog2(SINE_TABLE_ENTRIES);
   localparam int ENTRIES_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int IDX_PROD_W = PHASE_BITS + ENTRIES_W;
   localparam int FRAC_W = PHASE_BITS - dtg_pkg::RATE_SHIFT;

   typedef logic [FRAC_W-1:0] frac_lut_type [2**dtg_pkg::REM_W];

   // floor(r * 2^(P-7) / 125): fractional part of the step for remainder r
   function automatic frac_lut_type build_frac_lut();
      frac_lut_type lut;
      for (int r = 0; r < 2**dtg_pkg::REM_W; r++) begin
         lut[r] = FRAC_W'((64'(r) << FRAC_W) / dtg_pkg::STEP_DIVISOR);
      end
      return lut;
   endfunction

   localparam frac_lut_type FRAC_LUT = build_frac_lut();

   // tone state
   logic [PHASE_BITS-1:0]               phase_accum_ff;
   logic [PHASE_BITS-1:0]               phase_accum_in;
   logic [dtg_pkg::RATE_SHIFT-1:0]      step_quot_ff;   // step bits above the fraction
   logic [dtg_pkg::RATE_SHIFT-1:0]      step_quot_in;
   logic [dtg_pkg::REM_W-1:0]           step_rem_ff;    // selects the step fraction
   logic [dtg_pkg::REM_W-1:0]           step_rem_in;
   logic [dtg_pkg::LEFT_W-1:0]          samples_left_ff;
   logic [dtg_pkg::LEFT_W-1:0]          samples_left_in;
   logic [dtg_pkg::AMP_W-1:0]           amp_ff;
   logic [dtg_pkg::AMP_W-1:0]           amp_in;

   // pipeline
   dtg_pkg::stage_type                  s1_ff;
   dtg_pkg::stage_type                  s1_in;
   dtg_pkg::stage_type                  out_stage;

   logic                                advance;
   logic                                accept;
   logic                                playing;
   dtg_pkg::cmd_type                    cmd;
   logic [PHASE_BITS-1:0]               phase_step;
   logic [IDX_PROD_W-1:0]               idx_prod;
   logic [ADDR_W-1:0]                   rom_addr;
   logic signed [dtg_pkg::SAMPLE_W-1:0] rom_data;
   logic [dtg_pkg::RECIP_PROD_W-1:0]    recip_prod;
   logic [dtg_pkg::QUOT_W-1:0]          freq_quot;
   logic [dtg_pkg::FREQ_W-1:0]          freq_rem;

   // the whole pipeline moves when the output register is free or drained
   assign advance = !out_stage.valid || rsp_ready;
   assign req_ready = advance;
   assign accept = req_valid && advance;
   assign cmd = dtg_pkg::cmd_type'(req_command);
   assign playing = (samples_left_ff != '0);

   // freq = 125 * quot + rem; step = quot * 2^(P-7) + floor(rem * 2^(P-7) / 125)
   always_comb begin
      recip_prod = dtg_pkg::RECIP_PROD_W'(req_tone_freq_hz)
                   * dtg_pkg::RECIP_PROD_W'(dtg_pkg::STEP_RECIP);
      freq_quot = recip_prod[dtg_pkg::RECIP_SHIFT +: dtg_pkg::QUOT_W];
      freq_rem = req_tone_freq_hz
                 - dtg_pkg::FREQ_W'(dtg_pkg::FREQ_W'(freq_quot)
                                    * dtg_pkg::FREQ_W'(dtg_pkg::STEP_DIVISOR));
   end

   // only the low quotient bits survive the wrap of the phase
   assign phase_step = {step_quot_ff, FRAC_LUT[step_rem_ff]};

   // rom index = floor(phase * entries / 2^P)
   assign idx_prod = IDX_PROD_W'(phase_accum_ff) * IDX_PROD_W'(SINE_TABLE_ENTRIES);
   assign rom_addr = idx_prod[PHASE_BITS +: ADDR_W];

   always_comb begin
      phase_accum_in = phase_accum_ff;
      step_quot_in = step_quot_ff;
      step_rem_in = step_rem_ff;
      samples_left_in = samples_left_ff;
      amp_in = amp_ff;
      s1_in = s1_ff;

      if (csr_write_enable) begin
         amp_in = dtg_pkg::AMP_LUT[csr_write_data];
      end

      if (advance) begin
         s1_in.valid = accept && (cmd == dtg_pkg::CMD_TICK);
         s1_in.active = playing;
         s1_in.last = (samples_left_ff == dtg_pkg::LEFT_W'(1));
      end

      if (accept) begin
         case (cmd)
            dtg_pkg::CMD_START: begin
               if (req_tone_freq_hz != '0 && req_tone_duration_ms != '0) begin
                  step_quot_in = freq_quot[dtg_pkg::RATE_SHIFT-1:0];
                  step_rem_in = freq_rem[dtg_pkg::REM_W-1:0];
                  samples_left_in = dtg_pkg::LEFT_W'({req_tone_duration_ms,
                                                      {dtg_pkg::MS_SHIFT{1'b0}}});
               end
            end
            dtg_pkg::CMD_TICK: begin
               // idle tick leaves phase and count alone
               if (playing) begin
                  samples_left_in = samples_left_ff - dtg_pkg::LEFT_W'(1);
                  phase_accum_in = phase_accum_ff + phase_step;
               end
            end
            dtg_pkg::CMD_STOP: begin
               samples_left_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_accum_ff <= '0;
         step_quot_ff <= '0;
         step_rem_ff <= '0;
         samples_left_ff <= '0;
         amp_ff <= dtg_pkg::AMP_LUT[dtg_pkg::VOLUME_RESET];
         s1_ff <= '0;
      end else begin
         phase_accum_ff <= phase_accum_in;
         step_quot_ff <= step_quot_in;
         step_rem_ff <= step_rem_in;
         samples_left_ff <= samples_left_in;
         amp_ff <= amp_in;
         s1_ff <= s1_in;
      end
   end

   // rom read lines up with s1
   dtg_sine_rom #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_sine_rom (
      .clock        (clock),
      .read_enable  (advance),
      .read_address (rom_addr),
      .read_data    (rom_data)
   );

   // product stage, then divide and output register
   dtg_sample_scale u_sample_scale (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .stage_in     (s1_ff),
      .rom_data     (rom_data),
      .amp          (amp_ff),
      .stage_out    (out_stage),
      .sample_value (rsp_sample_value)
   );

   assign rsp_valid = out_stage.valid;
   assign rsp_tone_active = out_stage.active;
   assign rsp_tone_last = out_stage.last;

   // an idle result is all zero
   `ASSERT_IMPLIES(a_idle_result_zero, clock, reset,
      rsp_valid && !rsp_tone_active,
      rsp_sample_value == '0 && !rsp_tone_last,
      "idle result carries a sample or a last flag")

   // a valid start loads a nonzero sample count
   `ASSERT_NEXT(a_start_loads_count, clock, reset,
      accept && cmd == dtg_pkg::CMD_START && req_tone_freq_hz != '0
         && req_tone_duration_ms != '0,
      samples_left_ff != '0,
      "start did not load the sample count")

   // stop always ends the tone
   `ASSERT_NEXT(a_stop_clears_count, clock, reset,
      accept && cmd == dtg_pkg::CMD_STOP,
      samples_left_ff == '0,
      "stop left the tone playing")

   // an idle tick keeps the phase
   `ASSERT_NEXT(a_idle_tick_holds_phase, clock, reset,
      accept && cmd == dtg_pkg::CMD_TICK && !playing,
      $stable(phase_accum_ff),
      "idle tick moved the phase")

endmodule
